// ===== sv/stlru_pkg.sv =====
`timescale 1ns / 1ps

package stlru_pkg;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef logic [1:0] command_type;

   localparam command_type CMD_READ    = 2'd0;
   localparam command_type CMD_WRITE   = 2'd1;
   localparam command_type CMD_INSTALL = 2'd2;

endpackage

// ===== sv/set_assoc_tag_store_lru.sv =====
// Channel   Ports                                         Handshake
// --------  --------------------------------------------  ---------------------------------
// request   req_command, req_addr                         start && !busy
// response  rsp_hit, rsp_way_used, rsp_writeback_valid,   rsp_strobe, one cycle, no stall
//           rsp_evicted_dirty, rsp_victim_addr
// csr       csr_wr_data (clean writeback)                 csr_wr_en
//
// A request: the accept edge reads the set row from the tag and state memories, the lookup
// state compares the ways and picks the victim, and the update state writes the changed row back.
// The response strobe is high in the update state; busy falls with it.
// After reset a clearing pass zeroes the state memory one set at a time; busy stays high.
// The receiver cannot stall: each response is shown for exactly one cycle.
`timescale 1ns / 1ps

module set_assoc_tag_store_lru #(
   parameter int SETS        = 256,
   parameter int WAYS        = 8,
   parameter int BLOCK_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_addr,
   output logic        busy,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic [2:0]  rsp_way_used,
   output logic        rsp_writeback_valid,
   output logic        rsp_evicted_dirty,
   output logic [31:0] rsp_victim_addr,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int OFF_W     = $clog2(BLOCK_BYTES + 1) - 1;
   localparam int SET_W     = $clog2(SETS + 1) - 1;
   localparam int TAG_LSB   = OFF_W + SET_W;
   localparam int TAG_W     = 32 - TAG_LSB;
   localparam int SET_IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_W     = WAY_W;

   localparam logic [AGE_W-1:0]     OLDEST   = AGE_W'(WAYS - 1);
   localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(SETS - 1);
   localparam logic [31:0]          SET_MASK = 32'(SETS - 1);

   typedef struct packed {
      logic [WAYS-1:0]            valid;
      logic [WAYS-1:0]            dirty;
      logic [WAYS-1:0][AGE_W-1:0] age;
   } meta_row_type;

   typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_type;

   tag_row_type  tag_mem  [SETS];
   meta_row_type meta_mem [SETS];

   stlru_pkg::state_type    state_ff, state_in;
   logic [SET_IDX_W-1:0]    clr_ptr_ff, clr_ptr_in;
   logic                    wb_clean_ff;

   stlru_pkg::command_type  cmd_ff;
   logic [SET_IDX_W-1:0]    set_ff;
   logic [TAG_W-1:0]        tag_ff;
   tag_row_type             tag_rd_ff;
   meta_row_type            meta_rd_ff;

   logic                    hit_ff, hit_in;
   logic [WAY_W-1:0]        way_ff, way_in;
   logic                    wb_ff, wb_in;
   logic                    edirty_ff, edirty_in;
   logic [31:0]             eaddr_ff, eaddr_in;
   logic [AGE_W-1:0]        cur_ff, cur_in;
   logic                    upd_ff, upd_in;
   logic                    fill_ff, fill_in;
   logic                    dirty_wr_ff, dirty_wr_in;
   logic                    dirty_val_ff, dirty_val_in;

   logic                    accept;
   logic [SET_IDX_W-1:0]    req_set;
   logic [WAYS-1:0]         match;
   logic [WAYS-1:0]         old_way;
   logic [WAY_W-1:0]        hit_way;
   logic [WAY_W-1:0]        free_way;
   logic [WAY_W-1:0]        victim;
   logic                    found;
   logic                    has_free;

   meta_row_type            meta_new;
   tag_row_type             tag_new;
   logic                    meta_we;
   logic [SET_IDX_W-1:0]    meta_wa;
   meta_row_type            meta_wd;
   logic                    tag_we;

   assign accept  = start && (state_ff == stlru_pkg::ST_IDLE);
   assign req_set = SET_IDX_W'((req_addr >> OFF_W) & SET_MASK);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stlru_pkg::ST_CLEAR: begin
            if (clr_ptr_ff == LAST_SET) state_in = stlru_pkg::ST_IDLE;
         end
         stlru_pkg::ST_IDLE: begin
            if (start) state_in = stlru_pkg::ST_LOOKUP;
         end
         stlru_pkg::ST_LOOKUP: state_in = stlru_pkg::ST_UPDATE;
         stlru_pkg::ST_UPDATE: state_in = stlru_pkg::ST_IDLE;
         default: state_in = stlru_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      if (state_ff == stlru_pkg::ST_CLEAR) clr_ptr_in = clr_ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= stlru_pkg::ST_CLEAR;
         clr_ptr_ff  <= '0;
         wb_clean_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
         if (csr_wr_en) wb_clean_ff <= csr_wr_data;
      end
   end

   // lookup: compare ways, pick hit, free or oldest way
   always_comb begin
      match   = '0;
      old_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w]   = meta_rd_ff.valid[w] && (tag_rd_ff[w] == tag_ff);
         old_way[w] = (meta_rd_ff.age[w] == OLDEST);
      end
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) hit_way = WAY_W'(w);
         if (!meta_rd_ff.valid[w]) free_way = WAY_W'(w);
      end
      victim = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (old_way[w]) victim = WAY_W'(w);
      end
      found    = |match;
      has_free = ~&meta_rd_ff.valid;
   end

   always_comb begin
      hit_in       = 1'b0;
      way_in       = '0;
      wb_in        = 1'b0;
      edirty_in    = 1'b0;
      eaddr_in     = '0;
      cur_in       = '0;
      upd_in       = 1'b0;
      fill_in      = 1'b0;
      dirty_wr_in  = 1'b0;
      dirty_val_in = 1'b0;
      case (cmd_ff)
         stlru_pkg::CMD_READ, stlru_pkg::CMD_WRITE: begin
            if (found) begin
               hit_in       = 1'b1;
               way_in       = hit_way;
               cur_in       = meta_rd_ff.age[hit_way];
               upd_in       = 1'b1;
               dirty_wr_in  = (cmd_ff == stlru_pkg::CMD_WRITE);
               dirty_val_in = 1'b1;
            end
         end
         stlru_pkg::CMD_INSTALL: begin
            upd_in      = 1'b1;
            dirty_wr_in = 1'b1;
            if (found) begin
               hit_in = 1'b1;
               way_in = hit_way;
               cur_in = meta_rd_ff.age[hit_way];
            end else if (has_free) begin
               fill_in = 1'b1;
               way_in  = free_way;
               cur_in  = OLDEST;
            end else begin
               fill_in   = 1'b1;
               way_in    = victim;
               cur_in    = meta_rd_ff.age[victim];
               edirty_in = meta_rd_ff.dirty[victim];
               wb_in     = meta_rd_ff.dirty[victim] || wb_clean_ff;
               if (meta_rd_ff.dirty[victim] || wb_clean_ff) begin
                  eaddr_in = (32'(tag_rd_ff[victim]) << TAG_LSB) | (32'(set_ff) << OFF_W);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         set_ff <= req_set;
         tag_ff <= TAG_W'(req_addr >> TAG_LSB);
      end
      if (state_ff == stlru_pkg::ST_LOOKUP) begin
         hit_ff       <= hit_in;
         way_ff       <= way_in;
         wb_ff        <= wb_in;
         edirty_ff    <= edirty_in;
         eaddr_ff     <= eaddr_in;
         cur_ff       <= cur_in;
         upd_ff       <= upd_in;
         fill_ff      <= fill_in;
         dirty_wr_ff  <= dirty_wr_in;
         dirty_val_ff <= dirty_val_in;
      end
   end

   // update: age younger ways, refresh the used way
   always_comb begin
      meta_new = meta_rd_ff;
      for (int w = 0; w < WAYS; w++) begin
         if ((WAY_W'(w) != way_ff) && meta_rd_ff.valid[w] && (meta_rd_ff.age[w] < cur_ff)) begin
            meta_new.age[w] = AGE_W'(meta_rd_ff.age[w] + 1'b1);
         end
      end
      meta_new.age[way_ff] = '0;
      if (fill_ff) meta_new.valid[way_ff] = 1'b1;
      if (dirty_wr_ff) meta_new.dirty[way_ff] = dirty_val_ff;
      tag_new = tag_rd_ff;
      tag_new[way_ff] = tag_ff;
   end

   always_comb begin
      if (state_ff == stlru_pkg::ST_CLEAR) begin
         meta_we = 1'b1;
         meta_wa = clr_ptr_ff;
         meta_wd = '0;
      end else begin
         meta_we = (state_ff == stlru_pkg::ST_UPDATE) && upd_ff;
         meta_wa = set_ff;
         meta_wd = meta_new;
      end
      tag_we = (state_ff == stlru_pkg::ST_UPDATE) && fill_ff;
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      if (accept) meta_rd_ff <= meta_mem[req_set];
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[set_ff] <= tag_new;
      if (accept) tag_rd_ff <= tag_mem[req_set];
   end

   // outputs
   always_comb begin
      busy                = (state_ff != stlru_pkg::ST_IDLE);
      rsp_strobe          = (state_ff == stlru_pkg::ST_UPDATE);
      rsp_hit             = hit_ff;
      rsp_way_used        = 3'(way_ff);
      rsp_writeback_valid = wb_ff;
      rsp_evicted_dirty   = edirty_ff;
      rsp_victim_addr     = eaddr_ff;
   end

   a_full_set_one_oldest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stlru_pkg::ST_LOOKUP && (&meta_rd_ff.valid)) |-> $onehot(old_way))
      else $error("full set without a unique oldest way");

   a_hit_way_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stlru_pkg::ST_UPDATE && hit_ff)
      |-> (meta_rd_ff.valid[way_ff] && (tag_rd_ff[way_ff] == tag_ff)))
      else $error("reported hit way does not hold the tag");

   a_response_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("response not given two cycles after accept");

   a_writeback_on_eviction: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_writeback_valid)
      |-> (!rsp_hit && cmd_ff == stlru_pkg::CMD_INSTALL && (rsp_evicted_dirty || wb_clean_ff)))
      else $error("writeback reported without a qualifying eviction");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int SETS         = 256;
   localparam int WAYS         = 8;
   localparam int OFFSET_BITS  = 5;
   localparam int INDEX_BITS   = 8;
   localparam int TAG_BITS     = 32 - OFFSET_BITS - INDEX_BITS;
   localparam int SETTLE_TICKS = 4;
   localparam int REPORT_LIMIT = 10;
   localparam int TAG_CHOICES  = 12;
   localparam int SET_CHOICES  = 4;

   localparam stlru_pkg::command_type CMD_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      ITEM_ACCESS,
      ITEM_SET_WRITEBACK,
      ITEM_HOLD
   } item_kind_type;

   typedef struct {
      item_kind_type          kind;
      stlru_pkg::command_type command;
      logic [31:0]            addr;
      logic                   wb_clean;
      int unsigned            idle_pct;
   } pending_item_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  way_used;
      logic        writeback_valid;
      logic        evicted_dirty;
      logic [31:0] victim_addr;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_command = stlru_pkg::CMD_READ;
   logic [31:0] req_addr = '0;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        busy;
   logic        rsp_strobe;
   logic        rsp_hit;
   logic [2:0]  rsp_way_used;
   logic        rsp_writeback_valid;
   logic        rsp_evicted_dirty;
   logic [31:0] rsp_victim_addr;

   pending_item_type  pending_items[$];
   lookup_result_type expected_lookups[$];
   int unsigned       settle_count = 0;
   int unsigned       error_count = 0;

   logic [TAG_BITS-1:0] shadow_tag   [SETS][WAYS];
   logic                shadow_valid [SETS][WAYS];
   logic                shadow_dirty [SETS][WAYS];
   logic [2:0]          shadow_age   [SETS][WAYS];
   logic                shadow_wb_clean = 1'b0;

   logic [TAG_BITS-1:0]   tag_choices [TAG_CHOICES];
   logic [INDEX_BITS-1:0] set_choices [SET_CHOICES];

   set_assoc_tag_store_lru #(
      .SETS        (SETS),
      .WAYS        (WAYS),
      .BLOCK_BYTES (32)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_command         (req_command),
      .req_addr            (req_addr),
      .busy                (busy),
      .rsp_strobe          (rsp_strobe),
      .rsp_hit             (rsp_hit),
      .rsp_way_used        (rsp_way_used),
      .rsp_writeback_valid (rsp_writeback_valid),
      .rsp_evicted_dirty   (rsp_evicted_dirty),
      .rsp_victim_addr     (rsp_victim_addr),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void refresh_age(int unsigned set_idx, int unsigned way_idx,
                                       logic [2:0] threshold);
      for (int w = 0; w < WAYS; w++) begin
         if (w != way_idx && shadow_valid[set_idx][w] && shadow_age[set_idx][w] < threshold)
            shadow_age[set_idx][w] = shadow_age[set_idx][w] + 3'd1;
      end
      shadow_age[set_idx][way_idx] = 3'd0;
   endfunction

   function automatic lookup_result_type predict_lookup(stlru_pkg::command_type cmd,
                                                        logic [31:0] addr);
      lookup_result_type   res;
      int unsigned         set_idx;
      int unsigned         way_idx;
      logic [TAG_BITS-1:0] tag;
      logic                found;
      logic                vacant;
      logic [2:0]          oldest;
      res     = '0;
      set_idx = 32'(addr[OFFSET_BITS +: INDEX_BITS]);
      tag     = addr[31 -: TAG_BITS];
      found   = 1'b0;
      vacant  = 1'b0;
      way_idx = 0;
      if (cmd == CMD_UNUSED)
         return res;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
            found   = 1'b1;
            way_idx = w;
         end
      end
      if (found) begin
         res.hit      = 1'b1;
         res.way_used = 3'(way_idx);
         refresh_age(set_idx, way_idx, shadow_age[set_idx][way_idx]);
         if (cmd == stlru_pkg::CMD_WRITE)
            shadow_dirty[set_idx][way_idx] = 1'b1;
         else if (cmd == stlru_pkg::CMD_INSTALL)
            shadow_dirty[set_idx][way_idx] = 1'b0;
         return res;
      end
      if (cmd != stlru_pkg::CMD_INSTALL)
         return res;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!shadow_valid[set_idx][w]) begin
            vacant  = 1'b1;
            way_idx = w;
         end
      end
      if (vacant) begin
         refresh_age(set_idx, way_idx, 3'(WAYS - 1));
      end else begin
         oldest = 3'd0;
         for (int w = 0; w < WAYS; w++) begin
            if (shadow_age[set_idx][w] >= oldest) begin
               oldest  = shadow_age[set_idx][w];
               way_idx = w;
            end
         end
         res.evicted_dirty   = shadow_dirty[set_idx][way_idx];
         res.writeback_valid = shadow_dirty[set_idx][way_idx] | shadow_wb_clean;
         if (res.writeback_valid)
            res.victim_addr = (32'(shadow_tag[set_idx][way_idx]) << (OFFSET_BITS + INDEX_BITS))
                              | (32'(set_idx) << OFFSET_BITS);
         refresh_age(set_idx, way_idx, shadow_age[set_idx][way_idx]);
      end
      shadow_tag[set_idx][way_idx]   = tag;
      shadow_valid[set_idx][way_idx] = 1'b1;
      shadow_dirty[set_idx][way_idx] = 1'b0;
      res.way_used                   = 3'(way_idx);
      return res;
   endfunction

   function automatic logic [31:0] make_addr(logic [TAG_BITS-1:0] tag,
                                             logic [INDEX_BITS-1:0] set_idx,
                                             logic [OFFSET_BITS-1:0] offset);
      return {tag, set_idx, offset};
   endfunction

   task automatic queue_access(stlru_pkg::command_type cmd, logic [31:0] addr,
                               int unsigned idle_pct);
      pending_item_type item;
      item.kind     = ITEM_ACCESS;
      item.command  = cmd;
      item.addr     = addr;
      item.wb_clean = 1'b0;
      item.idle_pct = idle_pct;
      pending_items = {pending_items, item};
   endtask

   task automatic queue_control(item_kind_type kind, logic value);
      pending_item_type item;
      item.kind     = kind;
      item.command  = stlru_pkg::CMD_READ;
      item.addr     = '0;
      item.wb_clean = value;
      item.idle_pct = 0;
      pending_items = {pending_items, item};
   endtask

   task automatic queue_random_accesses(int unsigned count, int unsigned idle_pct);
      int unsigned            pick;
      stlru_pkg::command_type cmd;
      logic [TAG_BITS-1:0]    tag;
      logic [INDEX_BITS-1:0]  set_idx;
      tag_choices[0] = '0;
      tag_choices[1] = '1;
      for (int k = 2; k < TAG_CHOICES; k++)
         tag_choices[k] = TAG_BITS'($urandom);
      for (int k = 0; k < SET_CHOICES; k++)
         set_choices[k] = INDEX_BITS'($urandom);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 5)
            cmd = CMD_UNUSED;
         else if (pick < 40)
            cmd = stlru_pkg::CMD_INSTALL;
         else if (pick < 70)
            cmd = stlru_pkg::CMD_READ;
         else
            cmd = stlru_pkg::CMD_WRITE;
         if ($urandom_range(7) == 0)
            set_idx = INDEX_BITS'($urandom);
         else
            set_idx = set_choices[$urandom_range(SET_CHOICES - 1)];
         if ($urandom_range(15) == 0)
            tag = TAG_BITS'($urandom);
         else
            tag = tag_choices[$urandom_range(TAG_CHOICES - 1)];
         queue_access(cmd, make_addr(tag, set_idx, OFFSET_BITS'($urandom)), idle_pct);
      end
   endtask

   always @(posedge clock) begin : driver
      pending_item_type head;
      logic             drive_next;
      logic             write_next;
      logic             quiet;
      drive_next = start;
      write_next = 1'b0;
      quiet      = expected_lookups.size() == 0 && !busy && !rsp_strobe && !start;
      if (reset) begin
         drive_next   = 1'b0;
         settle_count <= 0;
      end else begin
         if (start && !busy) begin
            expected_lookups = {expected_lookups, predict_lookup(req_command, req_addr)};
            drive_next = 1'b0;
         end
         if (!drive_next && pending_items.size() != 0) begin
            head = pending_items[0];
            if (head.kind == ITEM_ACCESS) begin
               if ($urandom_range(99) >= head.idle_pct) begin
                  drive_next  = 1'b1;
                  req_command <= head.command;
                  req_addr    <= head.addr;
                  void'(pending_items.pop_front());
               end
            end else if (quiet && settle_count >= SETTLE_TICKS) begin
               if (head.kind == ITEM_SET_WRITEBACK) begin
                  write_next      = 1'b1;
                  csr_wr_data     <= head.wb_clean;
                  shadow_wb_clean = head.wb_clean;
               end
               void'(pending_items.pop_front());
               quiet = 1'b0;
            end
         end
         settle_count <= quiet ? settle_count + 1 : 0;
      end
      start     <= drive_next;
      csr_wr_en <= write_next;
   end

   always @(posedge clock) begin : monitor
      lookup_result_type seen;
      lookup_result_type want;
      seen = {rsp_hit, rsp_way_used, rsp_writeback_valid, rsp_evicted_dirty, rsp_victim_addr};
      if (!reset && rsp_strobe) begin
         if (expected_lookups.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected response: hit=%0b way=%0d wb=%0b dirty=%0b addr=%08h",
                        seen.hit, seen.way_used, seen.writeback_valid, seen.evicted_dirty,
                        seen.victim_addr);
         end else begin
            want = expected_lookups.pop_front();
            if (seen.hit !== want.hit || seen.way_used !== want.way_used
                || seen.writeback_valid !== want.writeback_valid
                || seen.evicted_dirty !== want.evicted_dirty
                || seen.victim_addr !== want.victim_addr) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("response mismatch at %0t: expected hit=%0b way=%0d wb=%0b %s",
                           $realtime, want.hit, want.way_used, want.writeback_valid,
                           $sformatf("dirty=%0b addr=%08h", want.evicted_dirty,
                                     want.victim_addr));
                  $display("   got hit=%0b way=%0d wb=%0b dirty=%0b addr=%08h",
                           seen.hit, seen.way_used, seen.writeback_valid,
                           seen.evicted_dirty, seen.victim_addr);
               end
            end
         end
      end
   end

   initial begin
      for (int s = 0; s < SETS; s++) begin
         for (int w = 0; w < WAYS; w++) begin
            shadow_tag[s][w]   = '0;
            shadow_valid[s][w] = 1'b0;
            shadow_dirty[s][w] = 1'b0;
            shadow_age[s][w]   = 3'd0;
         end
      end

      queue_control(ITEM_SET_WRITEBACK, 1'b0);
      queue_access(stlru_pkg::CMD_READ, 32'h0000_0000, 0);
      queue_access(stlru_pkg::CMD_WRITE, 32'hFFFF_FFFF, 0);
      queue_access(CMD_UNUSED, 32'hFFFF_FFFF, 0);
      queue_access(stlru_pkg::CMD_INSTALL, 32'hFFFF_FFFF, 0);
      queue_access(stlru_pkg::CMD_READ, 32'hFFFF_FFE0, 0);
      queue_access(stlru_pkg::CMD_WRITE, 32'hFFFF_FFFF, 0);
      queue_access(stlru_pkg::CMD_INSTALL, 32'hFFFF_FFE5, 0);
      for (int k = 0; k < WAYS; k++)
         queue_access(stlru_pkg::CMD_INSTALL, make_addr(TAG_BITS'(k), '0, OFFSET_BITS'(k)), 0);
      queue_access(stlru_pkg::CMD_WRITE, make_addr(TAG_BITS'(2), '0, '1), 0);
      queue_access(stlru_pkg::CMD_READ, make_addr('0, '0, '0), 0);
      for (int k = 8; k < 11; k++)
         queue_access(stlru_pkg::CMD_INSTALL, make_addr(TAG_BITS'(k), '0, '0), 0);
      queue_control(ITEM_SET_WRITEBACK, 1'b1);
      for (int k = 11; k < 14; k++)
         queue_access(stlru_pkg::CMD_INSTALL, make_addr(TAG_BITS'(k), '0, '0), 0);

      queue_random_accesses(290, 24);
      queue_control(ITEM_HOLD, 1'b0);
      queue_random_accesses(290, 24);
      queue_control(ITEM_SET_WRITEBACK, 1'b0);
      queue_random_accesses(580, 88);
      queue_control(ITEM_SET_WRITEBACK, 1'b1);
      queue_random_accesses(300, 0);
      queue_control(ITEM_SET_WRITEBACK, 1'b0);
      queue_random_accesses(290, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_items.size() != 0 || start || expected_lookups.size() != 0);
      repeat (8) @(negedge clock);
      if (error_count == 0 && expected_lookups.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== set_assoc_tag_store_lru.f =====
sv/stlru_pkg.sv
sv/set_assoc_tag_store_lru.sv
tb/tb_top.sv
